// ----- hw/rtl/conv2d_padded_mac_defines.svh -----
// Assertion macros for the convolution block's RTL, included by conv2d_padded_mac.sv
`ifndef CONV2D_PADDED_MAC_DEFINES_SVH
`define CONV2D_PADDED_MAC_DEFINES_SVH

// same-cycle implication, checked on clk, quiet while reset is held
`define C2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv2d check failed");

// next-cycle implication, checked on clk, quiet while reset is held
`define C2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv2d check failed");

`endif

// ----- hw/rtl/conv2d_pkg.sv -----
// Shared types and constants of the padded 2D convolution block
package conv2d_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] OP_LOAD_ACT    = 2'd2;
    localparam logic [1:0] OP_COMPUTE     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_IN_CHANNELS  = 3'd0;
    localparam logic [2:0] CFG_OUT_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_KERNEL_SIDE  = 3'd2;
    localparam logic [2:0] CFG_PAD_AMOUNT   = 3'd3;
    localparam logic [2:0] CFG_IN_HEIGHT    = 3'd4;
    localparam logic [2:0] CFG_IN_WIDTH     = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    // stream payload widths (IN_DATA_W and OUT_DATA_W in whole bytes)
    localparam int IN_DATA_W  = 40;
    localparam int IN_ITEM_W  = 34;
    localparam int OUT_DATA_W = 16;

    // accumulator: Q.22 products plus bias shifted up by 14, with headroom
    localparam int ACC_W = 48;

    // input item as packed in tdata, out_chan in the lowest bits
    typedef struct packed {
        logic signed [15:0] value;
        logic [4:0]         col;
        logic [4:0]         row;
        logic [3:0]         in_chan;
        logic [3:0]         out_chan;
    } in_item_t;

endpackage

// ----- hw/rtl/conv2d_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data
module conv2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/conv2d_padded_mac.sv -----
// Padded stride-one 2D convolution with a single multiply-accumulate over stored operands
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser op, tdata out_chan/in_chan/row/col/value
//  m_*      out  m_tvalid/m_tready  tdata result_value, tuser out_of_range
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// The length of a compute is set by the one multiplier walking every tap through the
// weight and activation RAM read ports; padded taps are read but not summed. An
// out-of-range compute skips the tap walk and goes straight to its result. Reset
// clears the bias valid bits and the control state; the activation and weight RAMs
// need no clearing pass. Input is held off from the accept of a compute until its
// result sits in the output register; loads keep flowing while that result waits
// for m_tready.
`include "conv2d_padded_mac_defines.svh"

module conv2d_padded_mac #(
    parameter int MAX_IN_CHANNELS  = 16,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int MAX_HEIGHT       = 32,
    parameter int MAX_WIDTH        = 32,
    parameter int MAX_KERNEL       = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [conv2d_pkg::IN_DATA_W-1:0]     s_tdata,  // out_chan, in_chan, row, col, value
    input  logic [1:0]                           s_tuser,  // op
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [conv2d_pkg::OUT_DATA_W-1:0]    m_tdata,  // result_value
    output logic                                 m_tuser,  // out_of_range
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [conv2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [conv2d_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import conv2d_pkg::*;

    localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int ACT_AW    = ACT_DEPTH > 1 ? $clog2(ACT_DEPTH) : 1;
    localparam int WGT_AW    = WGT_DEPTH > 1 ? $clog2(WGT_DEPTH) : 1;
    localparam int BIAS_AW   = MAX_OUT_CHANNELS > 1 ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int IC_W      = MAX_IN_CHANNELS > 1 ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int KMAX      = MAX_KERNEL < 3 ? MAX_KERNEL : 3;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BIAS  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    in_item_t item;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [4:0] in_ch_reg;
    logic [4:0] out_ch_reg;
    logic [1:0] ksize_reg;
    logic [1:0] pad_reg;
    logic [5:0] height_reg;
    logic [5:0] width_reg;

    // effective (clamped) configuration
    logic [31:0]        nic;
    logic [31:0]        noc;
    logic [31:0]        keff;
    logic [31:0]        peff;
    logic [31:0]        heff;
    logic [31:0]        weff;
    logic signed [31:0] out_rows;
    logic signed [31:0] out_cols;

    // request and tap walk
    logic [3:0]      oc_reg;
    logic [4:0]      row_reg;
    logic [4:0]      col_reg;
    logic            oor_reg;
    logic [IC_W-1:0] ic_cnt_reg;
    logic [1:0]      kr_reg;
    logic [1:0]      kc_reg;
    logic            drain_reg;

    logic               s_fire;
    logic               req_oor;
    logic signed [31:0] iy;
    logic signed [31:0] ix;
    logic               tap_ok;
    logic               tap_last;
    logic [31:0]        act_waddr_full;
    logic [31:0]        wgt_waddr_full;
    logic [31:0]        act_raddr_full;
    logic [31:0]        wgt_raddr_full;
    logic               act_we;
    logic               wgt_we;
    logic               bias_we;

    logic [15:0] act_rdata;
    logic [15:0] wgt_rdata;
    logic [15:0] bias_rdata;
    logic [MAX_OUT_CHANNELS-1:0] bias_valid_reg;

    // MAC pipeline
    logic                     ok_d1_reg;
    logic                     prod_ok_reg;
    logic signed [31:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_q;
    logic [15:0]              sat_value;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_oor_reg;
    logic        out_load;

    assign item      = in_item_t'(s_tdata[IN_ITEM_W-1:0]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp the registers into their ranges and derive the output size
    always_comb
    begin
        nic  = (in_ch_reg == 5'd0) ? 32'd1 :
               ((32'(in_ch_reg) > 32'(MAX_IN_CHANNELS)) ? 32'(MAX_IN_CHANNELS)
                                                         : 32'(in_ch_reg));
        noc  = (out_ch_reg == 5'd0) ? 32'd1 :
               ((32'(out_ch_reg) > 32'(MAX_OUT_CHANNELS)) ? 32'(MAX_OUT_CHANNELS)
                                                           : 32'(out_ch_reg));
        keff = (ksize_reg == 2'd0) ? 32'd1 :
               ((32'(ksize_reg) > 32'(KMAX)) ? 32'(KMAX) : 32'(ksize_reg));
        peff = (pad_reg > 2'd2) ? 32'd2 : 32'(pad_reg);
        heff = (height_reg == 6'd0) ? 32'd1 :
               ((32'(height_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_reg));
        weff = (width_reg == 6'd0) ? 32'd1 :
               ((32'(width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_reg));
        out_rows = signed'(heff + 32'd2 * peff - keff + 32'd1);
        out_cols = signed'(weff + 32'd2 * peff - keff + 32'd1);
    end

    assign req_oor = (32'(item.out_chan) >= noc) ||
                     (signed'(32'(item.row)) >= out_rows) ||
                     (signed'(32'(item.col)) >= out_cols);

    // load addresses and write enables
    always_comb
    begin
        act_waddr_full = (32'(item.in_chan) * 32'(MAX_HEIGHT) + 32'(item.row))
                         * 32'(MAX_WIDTH) + 32'(item.col);
        wgt_waddr_full = ((32'(item.out_chan) * 32'(MAX_IN_CHANNELS) + 32'(item.in_chan))
                         * 32'(MAX_KERNEL) + 32'(item.row)) * 32'(MAX_KERNEL)
                         + 32'(item.col);
        wgt_we  = s_fire && (s_tuser == OP_LOAD_WEIGHT) &&
                  (32'(item.out_chan) < 32'(MAX_OUT_CHANNELS)) &&
                  (32'(item.in_chan) < 32'(MAX_IN_CHANNELS)) &&
                  (32'(item.row) < 32'(MAX_KERNEL)) && (32'(item.col) < 32'(MAX_KERNEL));
        bias_we = s_fire && (s_tuser == OP_LOAD_BIAS) &&
                  (32'(item.out_chan) < 32'(MAX_OUT_CHANNELS));
        act_we  = s_fire && (s_tuser == OP_LOAD_ACT) &&
                  (32'(item.in_chan) < 32'(MAX_IN_CHANNELS)) &&
                  (32'(item.row) < 32'(MAX_HEIGHT)) && (32'(item.col) < 32'(MAX_WIDTH));
    end

    // tap position and read addresses; padded taps read anything and are dropped
    always_comb
    begin
        iy = signed'(32'(row_reg) + 32'(kr_reg)) - signed'(peff);
        ix = signed'(32'(col_reg) + 32'(kc_reg)) - signed'(peff);
        tap_ok = (iy >= 0) && (iy < signed'(heff)) && (ix >= 0) && (ix < signed'(weff));
        tap_last = (32'(kc_reg) == keff - 32'd1) && (32'(kr_reg) == keff - 32'd1) &&
                   (32'(ic_cnt_reg) == nic - 32'd1);
        act_raddr_full = (32'(ic_cnt_reg) * 32'(MAX_HEIGHT) + unsigned'(iy))
                         * 32'(MAX_WIDTH) + unsigned'(ix);
        wgt_raddr_full = ((32'(oc_reg) * 32'(MAX_IN_CHANNELS) + 32'(ic_cnt_reg))
                         * 32'(MAX_KERNEL) + 32'(kr_reg)) * 32'(MAX_KERNEL) + 32'(kc_reg);
    end

    // operand stores; loads only land while idle, and read data is only used while busy
    conv2d_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr_full[ACT_AW-1:0]),
        .wdata (item.value),
        .raddr (act_raddr_full[ACT_AW-1:0]),
        .rdata (act_rdata)
    );

    conv2d_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr_full[WGT_AW-1:0]),
        .wdata (item.value),
        .raddr (wgt_raddr_full[WGT_AW-1:0]),
        .rdata (wgt_rdata)
    );

    // bias read is issued in the accept beat of the compute
    conv2d_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (BIAS_AW'(32'(item.out_chan))),
        .wdata (item.value),
        .raddr (BIAS_AW'(32'(item.out_chan))),
        .rdata (bias_rdata)
    );

    // round half up, shift back to Q8.8, saturate
    always_comb
    begin
        rnd_sum = acc_reg + ACC_W'(8192);
        rnd_q   = rnd_sum >>> 14;
        if (rnd_q > ACC_W'(32767))
        begin
            sat_value = 16'h7fff;
        end
        else if (rnd_q < -ACC_W'(32768))
        begin
            sat_value = 16'h8000;
        end
        else
        begin
            sat_value = rnd_q[15:0];
        end
    end

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == OP_COMPUTE))
                begin
                    state_next = req_oor ? ST_FIN : ST_BIAS;
                end
            end
            ST_BIAS:  state_next = ST_RUN;
            ST_RUN:
            begin
                if (tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and bias valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_ch_reg      <= 5'd1;
            out_ch_reg     <= 5'd1;
            ksize_reg      <= 2'd3;
            pad_reg        <= 2'd1;
            height_reg     <= 6'd32;
            width_reg      <= 6'd32;
            bias_valid_reg <= '0;
            ic_cnt_reg     <= '0;
            kr_reg         <= 2'd0;
            kc_reg         <= 2'd0;
            drain_reg      <= 1'b0;
            ok_d1_reg      <= 1'b0;
            prod_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IN_CHANNELS:  in_ch_reg  <= cfg_data[4:0];
                    CFG_OUT_CHANNELS: out_ch_reg <= cfg_data[4:0];
                    CFG_KERNEL_SIDE:  ksize_reg  <= cfg_data[1:0];
                    CFG_PAD_AMOUNT:   pad_reg    <= cfg_data[1:0];
                    CFG_IN_HEIGHT:    height_reg <= cfg_data;
                    CFG_IN_WIDTH:     width_reg  <= cfg_data;
                    default:          ;
                endcase
            end

            if (bias_we)
            begin
                bias_valid_reg[BIAS_AW'(32'(item.out_chan))] <= 1'b1;
            end

            // tap walk: kernel column, then kernel row, then input channel
            if (state_reg == ST_BIAS)
            begin
                ic_cnt_reg <= '0;
                kr_reg     <= 2'd0;
                kc_reg     <= 2'd0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (32'(kc_reg) != keff - 32'd1)
                begin
                    kc_reg <= kc_reg + 2'd1;
                end
                else
                begin
                    kc_reg <= 2'd0;
                    if (32'(kr_reg) != keff - 32'd1)
                    begin
                        kr_reg <= kr_reg + 2'd1;
                    end
                    else
                    begin
                        kr_reg     <= 2'd0;
                        ic_cnt_reg <= ic_cnt_reg + IC_W'(1);
                    end
                end
            end

            drain_reg   <= (state_reg == ST_DRAIN) && !drain_reg;
            ok_d1_reg   <= (state_reg == ST_RUN) && tap_ok;
            prod_ok_reg <= ok_d1_reg;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: request capture, multiply, accumulate, result
    always_ff @(posedge clk)
    begin
        if (s_fire && (s_tuser == OP_COMPUTE))
        begin
            oc_reg  <= item.out_chan;
            row_reg <= item.row;
            col_reg <= item.col;
            oor_reg <= req_oor;
        end

        prod_reg <= $signed(wgt_rdata) * $signed(act_rdata);

        if (state_reg == ST_BIAS)
        begin
            acc_reg <= bias_valid_reg[BIAS_AW'(32'(oc_reg))]
                       ? {{(ACC_W - 30){bias_rdata[15]}}, bias_rdata, 14'd0}
                       : '0;
        end
        else if (prod_ok_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - 32){prod_reg[31]}}, prod_reg};
        end

        if (out_load)
        begin
            out_value_reg <= oor_reg ? 16'd0 : sat_value;
            out_oor_reg   <= oor_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_oor_reg;

    // the MAC pipeline is empty by the time the result is formed
    `C2D_ASSERT_NOW(a_drained_at_fin, state_reg == ST_FIN, !ok_d1_reg && !prod_ok_reg)
    // products only arrive while a compute is under way
    `C2D_ASSERT_NOW(a_prod_in_compute, prod_ok_reg,
                    state_reg == ST_RUN || state_reg == ST_DRAIN)
    // an out-of-range result carries a zero value
    `C2D_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser, m_tdata == 16'd0)
    // an in-range compute starts by fetching its bias
    `C2D_ASSERT_NEXT(a_compute_starts, s_fire && (s_tuser == OP_COMPUTE) && !req_oor,
                     state_reg == ST_BIAS)

endmodule
